### hw/rtl/bol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_pkg: shared types for the bounded ordered list
// operation and status codes, decode plan and sequencer states
// ----------------------------------------------------------------------------
package bol_pkg;

  typedef enum logic [2:0] {
    OP_ADD_HEAD  = 3'd0,
    OP_ADD_TAIL  = 3'd1,
    OP_INS_AFTER = 3'd2,
    OP_DEL_HEAD  = 3'd3,
    OP_DEL_TAIL  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ_ALL  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // what the sequencer has to do for one transaction
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SHRINK,
    ACT_INS,
    ACT_DEL,
    ACT_DUMP
  } act_t;

  typedef struct packed {
    status_t status;
    act_t    act;
  } plan_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_DUMP
  } state_t;

  localparam logic [3:0] FILL_LIMIT_RST = 4'd7;

endpackage

### hw/rtl/bol_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_ram: generic single-write, single-read memory
// one write port, one read port with registered read data, no reset
// ----------------------------------------------------------------------------
module bol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/bol_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_dec: operation decode
// checks limit, emptiness and position and plans the slot walk
// ----------------------------------------------------------------------------
module bol_dec #(
  parameter int DEPTH = 8,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic [2:0]     op,
  input  logic [3:0]     position,
  input  logic [CW-1:0]  fill,
  input  logic [3:0]     limit,
  output bol_pkg::plan_t plan,
  output logic [CW-1:0]  slot,
  output logic [CW-1:0]  moves
);

  localparam int EW = ((CW > 4) ? CW : 4) + 1;

  logic [EW-1:0] c_e;
  logic [EW-1:0] p_e;
  logic [EW-1:0] lim_e;
  logic [EW-1:0] depth_e;
  logic [EW-1:0] eff_e;
  logic [EW-1:0] slot_e;
  logic [EW-1:0] moves_e;
  logic          full;
  logic          empty;
  logic          past_end;

  always_comb begin
    c_e      = EW'(fill);
    lim_e    = EW'(limit);
    depth_e  = EW'(DEPTH);
    eff_e    = (lim_e > depth_e) ? depth_e : lim_e;
    // position zero counts as the head
    p_e      = (position == 4'd0) ? EW'(1) : EW'(position);
    full     = (c_e >= eff_e);
    empty    = (c_e == '0);
    past_end = (p_e > c_e);

    plan.status = bol_pkg::ST_OK;
    plan.act    = bol_pkg::ACT_NONE;
    slot_e      = '0;
    moves_e     = '0;

    case (op)
      bol_pkg::OP_ADD_HEAD: begin
        if (full) begin
          plan.status = bol_pkg::ST_FULL;
        end else begin
          plan.act = bol_pkg::ACT_INS;
          moves_e  = c_e;
        end
      end
      bol_pkg::OP_ADD_TAIL: begin
        if (full) begin
          plan.status = bol_pkg::ST_FULL;
        end else begin
          plan.act = bol_pkg::ACT_INS;
          slot_e   = c_e;
        end
      end
      bol_pkg::OP_INS_AFTER: begin
        if (full) begin
          plan.status = bol_pkg::ST_FULL;
        end else if (past_end) begin
          plan.status = bol_pkg::ST_BADPOS;
        end else begin
          plan.act = bol_pkg::ACT_INS;
          slot_e   = p_e;
          moves_e  = c_e - p_e;
        end
      end
      bol_pkg::OP_DEL_HEAD: begin
        if (empty) begin
          plan.status = bol_pkg::ST_EMPTY;
        end else begin
          plan.act = bol_pkg::ACT_DEL;
          moves_e  = c_e - EW'(1);
        end
      end
      bol_pkg::OP_DEL_TAIL: begin
        if (empty) begin
          plan.status = bol_pkg::ST_EMPTY;
        end else begin
          plan.act = bol_pkg::ACT_SHRINK;
        end
      end
      bol_pkg::OP_DEL_AT: begin
        if (empty) begin
          plan.status = bol_pkg::ST_EMPTY;
        end else if (past_end) begin
          plan.status = bol_pkg::ST_BADPOS;
        end else begin
          plan.act = bol_pkg::ACT_DEL;
          slot_e   = p_e - EW'(1);
          moves_e  = c_e - p_e;
        end
      end
      bol_pkg::OP_READ_ALL: begin
        if (empty) begin
          plan.status = bol_pkg::ST_EMPTY;
        end else begin
          plan.act = bol_pkg::ACT_DUMP;
        end
      end
      default: begin
        plan.status = bol_pkg::ST_OK;
      end
    endcase

    slot  = slot_e[CW-1:0];
    moves = moves_e[CW-1:0];
  end

endmodule

### hw/rtl/bounded_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list: list of up to min(fill_limit, DEPTH) words with positional
// insert and delete, kept in a single-port-write RAM and walked one slot a cycle
// ----------------------------------------------------------------------------
// error results, op 7 and tail delete answer straight from the idle state with
//   busy staying low, so the next transaction may follow at once
// insert/delete: busy while m entries are shifted, where m is at most DEPTH - 1,
//   one RAM move per cycle; the new word is then written or the count dropped,
//   and busy falls as the result is strobed
// read-all: n results on consecutive cycles, n being the count of entries
// results are strobed for one cycle and cannot be held off by the receiver
// reset (rst_n low, synchronous) empties the list, sets fill_limit to 7 and
//   idles the sequencer; RAM contents are left as they are
// ----------------------------------------------------------------------------
module bounded_ordered_list #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // transaction request
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_value,
  input  logic [3:0]  in_position,
  // result strobe
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_entry_value,
  output logic        out_last,
  output logic [3:0]  out_count,
  // fill limit register
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW = DATA_WIDTH;

  // control state
  bol_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [3:0]      limit_r, limit_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;      // walk pointer: next RAM slot to read
  logic [CW-1:0]   moves_r, moves_nxt;  // moves still to issue
  logic            pend_r, pend_nxt;    // read data arrives this cycle
  logic            pend_last_r, pend_last_nxt;
  logic [AW-1:0]   wa_r, wa_nxt;        // where the arriving word goes
  logic            out_valid_r, out_valid_nxt;

  // transaction payload
  logic [AW-1:0]   slot_r, slot_nxt;
  logic [DW-1:0]   val_r, val_nxt;
  logic            ins_r, ins_nxt;

  // result payload
  bol_pkg::status_t out_status_r, out_status_nxt;
  logic [31:0]      out_entry_r, out_entry_nxt;
  logic             out_last_r, out_last_nxt;
  logic [3:0]       out_count_r, out_count_nxt;

  // decode
  bol_pkg::plan_t plan;
  logic [CW-1:0]  dec_slot;
  logic [CW-1:0]  dec_moves;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  // width adaptation
  logic [DW+31:0] val_ext;
  logic [DW+31:0] rd_ext;
  logic [CW+3:0]  fill_ext;
  logic [CW-1:0]  idx_up;
  logic [CW-1:0]  idx_dn;
  logic [CW-1:0]  slot_up;

  assign val_ext  = {{DW{1'b0}}, in_value};
  assign rd_ext   = {32'b0, ram_rdata};
  assign fill_ext = {4'b0, fill_nxt};
  assign idx_up   = idx_r + CW'(1);
  assign idx_dn   = idx_r - CW'(1);
  assign slot_up  = dec_slot + CW'(1);

  bol_dec #(
    .DEPTH (DEPTH)
  ) u_dec (
    .op       (in_op),
    .position (in_position),
    .fill     (fill_r),
    .limit    (limit_r),
    .plan     (plan),
    .slot     (dec_slot),
    .moves    (dec_moves)
  );

  bol_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    limit_nxt     = cfg_we ? cfg_wdata : limit_r;
    idx_nxt       = idx_r;
    moves_nxt     = moves_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    wa_nxt        = wa_r;
    slot_nxt      = slot_r;
    val_nxt       = val_r;
    ins_nxt       = ins_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = bol_pkg::ST_OK;
    out_entry_nxt  = 32'b0;
    out_last_nxt   = 1'b1;

    ram_we    = 1'b0;
    ram_waddr = wa_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_r[AW-1:0];

    case (state_r)
      bol_pkg::S_IDLE: begin
        if (start) begin
          val_nxt   = val_ext[DW-1:0];
          slot_nxt  = dec_slot[AW-1:0];
          ins_nxt   = (plan.act == bol_pkg::ACT_INS);
          moves_nxt = dec_moves;
          case (plan.act)
            bol_pkg::ACT_SHRINK: begin
              // tail delete only drops the count
              fill_nxt      = fill_r - CW'(1);
              out_valid_nxt = 1'b1;
            end
            bol_pkg::ACT_INS: begin
              // shift from the tail down toward the new slot
              idx_nxt   = fill_r - CW'(1);
              state_nxt = bol_pkg::S_MOVE;
            end
            bol_pkg::ACT_DEL: begin
              // pull entries behind the removed slot forward
              idx_nxt   = slot_up;
              state_nxt = bol_pkg::S_MOVE;
            end
            bol_pkg::ACT_DUMP: begin
              idx_nxt   = '0;
              state_nxt = bol_pkg::S_DUMP;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = plan.status;
            end
          endcase
        end
      end

      bol_pkg::S_MOVE: begin
        // word read last cycle lands one slot over
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (moves_r != '0) begin
          ram_re    = 1'b1;
          pend_nxt  = 1'b1;
          wa_nxt    = ins_r ? idx_up[AW-1:0] : idx_dn[AW-1:0];
          idx_nxt   = ins_r ? idx_dn : idx_up;
          moves_nxt = moves_r - CW'(1);
        end else if (!pend_r) begin
          // walk drained: drop in the new word or shrink
          if (ins_r) begin
            ram_we    = 1'b1;
            ram_waddr = slot_r;
            ram_wdata = val_r;
            fill_nxt  = fill_r + CW'(1);
          end else begin
            fill_nxt = fill_r - CW'(1);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = bol_pkg::S_IDLE;
        end
      end

      bol_pkg::S_DUMP: begin
        if (idx_r < fill_r) begin
          ram_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_last_nxt = (idx_r == fill_r - CW'(1));
          idx_nxt       = idx_up;
        end
        if (pend_r) begin
          out_valid_nxt = 1'b1;
          out_entry_nxt = rd_ext[31:0];
          out_last_nxt  = pend_last_r;
          if (pend_last_r) begin
            state_nxt = bol_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = bol_pkg::S_IDLE;
      end
    endcase

    // every result reports the count after the operation
    out_count_nxt = fill_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bol_pkg::S_IDLE;
      fill_r      <= '0;
      limit_r     <= bol_pkg::FILL_LIMIT_RST;
      idx_r       <= '0;
      moves_r     <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      wa_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      limit_r     <= limit_nxt;
      idx_r       <= idx_nxt;
      moves_r     <= moves_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      wa_r        <= wa_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    val_r        <= val_nxt;
    ins_r        <= ins_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign busy            = (state_r != bol_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_entry_r;
  assign out_last        = out_last_r;
  assign out_count       = out_count_r;

endmodule

### hw/rtl/bol_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_chk: port-level checks for the bounded ordered list
// result framing and request/result sequencing seen from the ports
// ----------------------------------------------------------------------------
module bol_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [31:0] out_entry_value,
  input logic        out_last
);

  // an accepted transaction either keeps the block busy or answers at once
  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transaction produced neither busy nor a result");

  // a read-out burst has no gaps
  a_burst_dense: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a read-out burst");

  // an error result is single (last) and carries a zero value
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bol_pkg::ST_OK) |-> (out_last && out_entry_value == 32'b0))
    else $error("error result not a single, zero-valued transaction");

  // the final result of a transaction frees the block
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("block still busy with its final result");

endmodule

bind bounded_ordered_list bol_chk u_bol_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_entry_value (out_entry_value),
  .out_last        (out_last)
);
